[sv/tspb_pkg.sv]
package tspb_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAX = 3'd4,
    OP_MIN = 3'd5
  } blend_op_t;

  localparam int unsigned SETUP_W = 30;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA = 3'd4;

  typedef struct packed {
    logic       swap;
    logic [2:0] op;
    logic [12:0] f2;
    logic [12:0] f1;
  } setup_t;

  // trunc(x/255) for x <= 255*255: (x + 1 + (x >> 8)) >> 8 is exact there
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

[sv/tspb_divider.sv]
// Pipelined restoring divider: quotient of p*255 / q, clamped to 255.
// One quotient bit per stage, 16 stages, zero divisor yields 0.
module tspb_divider (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] p,
  input  logic [7:0] q,
  output logic [7:0] res
);
  import tspb_pkg::*;

  localparam int unsigned NB = 16;

  // dividend and remainder are only needed up to the last stage's input
  logic [15:0] num [NB];
  logic [8:0]  rem [NB];
  logic [7:0]  dvs [NB+1];
  logic [15:0] quo [NB+1];

  assign num[0] = {8'd0, p} * 16'd255;
  assign rem[0] = 9'd0;
  assign dvs[0] = q;
  assign quo[0] = 16'd0;

  genvar i;
  generate
    for (i = 0; i < NB; i++) begin : g_st
      logic [9:0] sh;
      logic [9:0] df;
      assign sh = {rem[i], num[i][NB-1-i]};
      assign df = sh - {2'd0, dvs[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          dvs[i+1] <= dvs[i];
          quo[i+1] <= {quo[i][14:0], !df[9]};
        end
      end
      if (i < NB-1) begin : g_fwd
        always_ff @(posedge clk) begin
          if (en) begin
            num[i+1] <= num[i];
            rem[i+1] <= df[9] ? sh[8:0] : df[8:0];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    if (dvs[NB] == 8'd0) res = 8'd0;
    else if (quo[NB] > 16'd255) res = 8'd255;
    else res = quo[NB][7:0];
  end
endmodule

[sv/tspb_channel.sv]
// One channel: factor select, operand scale, operation, clamp.
// Stages: s1 factors+products, s2 div255+swap, s3 non-divide op plus delay
// line alongside the divider chain, final select; all advance on en.
module tspb_channel (
  input  logic                    clk,
  input  logic                    en,
  input  tspb_pkg::setup_t        setup,
  input  logic [1:0]              sel,
  input  logic [7:0]              s1 [4],
  input  logic [7:0]              s2 [4],
  output logic [7:0]              res
);
  import tspb_pkg::*;

  localparam int unsigned DL = 15;

  function automatic logic [7:0] fval(input logic [12:0] f, input logic [7:0] a [4],
                                      input logic [7:0] b [4]);
    logic [7:0] v;
    v = f[3] ? b[f[2:1]] : a[f[2:1]];
    if (f[4]) v = 8'd255 - v;
    if (f[0]) v = f[12:5];
    return v;
  endfunction

  // stage 1: raw products
  logic [15:0] pp1, qq1;
  logic [3:0]  ctl1;
  always_ff @(posedge clk) begin
    if (en) begin
      pp1 <= s1[sel] * fval(setup.f1, s1, s2);
      qq1 <= s2[sel] * fval(setup.f2, s1, s2);
      ctl1 <= {setup.swap, setup.op};
    end
  end

  // stage 2: scale and swap
  logic [7:0] p2, q2;
  logic [2:0] op2;
  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= ctl1[3] ? div255(qq1) : div255(pp1);
      q2 <= ctl1[3] ? div255(pp1) : div255(qq1);
      op2 <= ctl1[2:0];
    end
  end

  // stage 3: non-divide result, then delay to match divider
  logic [7:0] r3;
  logic       d3;
  logic [8:0] sum;
  logic [15:0] prod;
  assign sum = {1'b0, p2} + {1'b0, q2};
  assign prod = p2 * q2;
  always_ff @(posedge clk) begin
    if (en) begin
      d3 <= (op2 == OP_DIV);
      case (op2)
        OP_SUB: r3 <= (p2 > q2) ? p2 - q2 : 8'd0;
        OP_MUL: r3 <= div255(prod);
        OP_MAX: r3 <= (p2 > q2) ? p2 : q2;
        OP_MIN: r3 <= (p2 < q2) ? p2 : q2;
        default: r3 <= sum[8] ? 8'd255 : sum[7:0];
      endcase
    end
  end

  logic [7:0] rd [DL];
  logic       dd [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      rd[0] <= r3;
      dd[0] <= d3;
      for (int k = 1; k < DL; k++) begin
        rd[k] <= rd[k-1];
        dd[k] <= dd[k-1];
      end
    end
  end

  logic [7:0] dq;
  tspb_divider u_div (.clk(clk), .en(en), .p(p2), .q(q2), .res(dq));

  // divider output aligns with rd[DL-1]
  always_ff @(posedge clk) begin
    if (en) res <= dd[DL-1] ? dq : rd[DL-1];
  end
endmodule

[sv/two_source_pixel_blend.sv]
// Channel  | Dir | Signals                  | Content
// s_axis   | in  | tvalid/tready/tdata[63:0]| source one RGBA, source two RGBA
// m_axis   | out | tvalid/tready/tdata[31:0]| blended RGBA
// cfg      | in  | cfg_we/cfg_idx/cfg_data  | setup registers 0..4
//
// One pixel per clock while not stalled. Latency LAT is set by the 16-stage
// divider chain plus the operand stages. The whole pipeline advances when
// the output register is empty or taken; a stall freezes every stage and
// s_axis_tready drops with it. Reset clears valid bits and the setup
// registers (has_alpha to 1); data registers are not reset.
module two_source_pixel_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_red, first_green, first_blue, first_alpha,
  // second_red, second_green, second_blue, second_alpha
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [tspb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tspb_pkg::SETUP_W-1:0]   cfg_data
);
  import tspb_pkg::*;

  localparam int unsigned LAT = 19;

  setup_t setup [4];
  logic   has_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) setup[k] <= '0;
      has_alpha <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RED:       setup[0] <= cfg_data;
        REG_GREEN:     setup[1] <= cfg_data;
        REG_BLUE:      setup[2] <= cfg_data;
        REG_ALPHA:     setup[3] <= cfg_data;
        REG_HAS_ALPHA: has_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; output slot held while stalled
  logic en;
  logic [LAT-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end

  // alpha forced to 255 when absent
  logic [7:0] s1 [4];
  logic [7:0] s2 [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s1[k] = s_axis_tdata[8*k +: 8];
      s2[k] = s_axis_tdata[32 + 8*k +: 8];
    end
    if (!has_alpha) begin
      s1[3] = 8'd255;
      s2[3] = 8'd255;
    end
  end

  logic [7:0] res [4];
  genvar c;
  generate
    for (c = 0; c < 4; c++) begin : g_ch
      tspb_channel u_ch (
        .clk(clk), .en(en), .setup(setup[c]), .sel(2'(c)),
        .s1(s1), .s2(s2), .res(res[c])
      );
    end
  endgenerate

  // alpha-present flag rides with the data
  logic [LAT-1:0] ha;
  always_ff @(posedge clk) begin
    if (en) ha <= {ha[LAT-2:0], has_alpha};
  end

  assign m_axis_tdata = {ha[LAT-1] ? res[3] : 8'd0, res[2], res[1], res[0]};
endmodule
